// File: rtl/nts_pkg.sv
// Shared types and constants of the nearest texel sampler.
package nts_pkg;

    localparam int DIM_W       = 9;
    localparam int CHAN_W      = 3;
    localparam int LIN_W       = 18;
    localparam int BASE_W      = 20;
    localparam int CMP_W       = 21;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESENT  = 2'd3;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CHAN_W-1:0] CH_GREY       = 3'd1;
    localparam logic [CHAN_W-1:0] CH_GREY_ALPHA = 3'd2;
    localparam logic [CHAN_W-1:0] CH_RGB        = 3'd3;
    localparam logic [CHAN_W-1:0] CH_RGBA       = 3'd4;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_WHITE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef struct packed {
        logic              command;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
        logic [15:0]        write_address;
        logic [7:0]         write_byte;
    } nts_req_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] samples_taken;
        logic        address_error;
    } nts_rsp_t;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [CHAN_W-1:0] chans;
        logic              present;
    } nts_cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [CHAN_W-1:0]  chans;
        logic [BASE_W-1:0]  base;
        logic [15:0]        waddr;
        logic [7:0]         wbyte;
        logic [COUNT_W-1:0] count;
    } nts_job_t;

endpackage

// File: rtl/nts_front.sv
// Front pipeline: coordinate wrap and scale, texel address, transaction classification.
module nts_front
    import nts_pkg::*;
#(
    parameter int MAX_DIMENSION       = 256,
    parameter int COORD_FRACTION_BITS = 16,
    parameter int TEXEL_BYTES         = 65536
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  nts_cfg_t cfg,
    input  logic     req_valid,
    output logic     req_ready,
    input  nts_req_t req,
    output logic     job_valid,
    input  logic     job_ready,
    output nts_job_t job
);

    localparam int PROD_W = COORD_FRACTION_BITS + DIM_W;
    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIMENSION > (2 ** DIM_W) - 1) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIMENSION);
    localparam logic [CMP_W-1:0] MEM_LIMIT = CMP_W'(TEXEL_BYTES);

    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic               a_free;
    logic               b_free;
    logic               c_free;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    logic               a_valid_reg;
    logic               a_cmd_reg;
    logic [15:0]        a_waddr_reg;
    logic [7:0]         a_wbyte_reg;
    logic [COUNT_W-1:0] a_count_reg;
    logic [PROD_W-1:0]  a_px_reg;
    logic [PROD_W-1:0]  a_py_reg;
    logic [DIM_W-1:0]   a_w_reg;
    logic [DIM_W-1:0]   a_h_reg;

    logic               b_valid_reg;
    logic               b_cmd_reg;
    logic [15:0]        b_waddr_reg;
    logic [7:0]         b_wbyte_reg;
    logic [COUNT_W-1:0] b_count_reg;
    logic [LIN_W-1:0]   b_lin_reg;
    logic [LIN_W-1:0]   lin_next;

    logic               c_valid_reg;
    nts_job_t           c_job_reg;
    nts_job_t           c_job_next;

    logic [DIM_W-1:0]   x_raw;
    logic [DIM_W-1:0]   y_raw;
    logic [DIM_W-1:0]   x_pos;
    logic [DIM_W-1:0]   y_pos;
    logic [DIM_W-1:0]   y_flip;
    logic [BASE_W-1:0]  base;
    logic [CMP_W-1:0]   last_byte;

    // zero size acts as one, oversize as the cap
    always_comb
    begin
        if (cfg.width == '0)
            w_eff = DIM_W'(1);
        else if (cfg.width > DIM_CAP)
            w_eff = DIM_CAP;
        else
            w_eff = cfg.width;
        if (cfg.height == '0)
            h_eff = DIM_W'(1);
        else if (cfg.height > DIM_CAP)
            h_eff = DIM_CAP;
        else
            h_eff = cfg.height;
    end

    assign c_free    = !c_valid_reg || job_ready;
    assign b_free    = !b_valid_reg || c_free;
    assign a_free    = !a_valid_reg || b_free;
    assign req_ready = a_free;

    assign count_next = count_reg + COUNT_W'(1);

    // column and row from the scaled fraction
    always_comb
    begin
        x_raw    = a_px_reg[PROD_W-1 -: DIM_W];
        y_raw    = a_py_reg[PROD_W-1 -: DIM_W];
        x_pos    = (x_raw >= a_w_reg) ? a_w_reg - DIM_W'(1) : x_raw;
        y_pos    = (y_raw >= a_h_reg) ? a_h_reg - DIM_W'(1) : y_raw;
        y_flip   = a_h_reg - DIM_W'(1) - y_pos;
        lin_next = LIN_W'(y_flip) * LIN_W'(a_w_reg) + LIN_W'(x_pos);
    end

    always_comb
    begin
        base      = BASE_W'(b_lin_reg) * BASE_W'(cfg.chans);
        last_byte = CMP_W'(base) + CMP_W'(cfg.chans) - CMP_W'(1);
        c_job_next.chans = cfg.chans;
        c_job_next.base  = base;
        c_job_next.waddr = b_waddr_reg;
        c_job_next.wbyte = b_wbyte_reg;
        c_job_next.count = b_count_reg;
        if (b_cmd_reg == CMD_WRITE)
            c_job_next.kind = KIND_WRITE;
        else if (!cfg.present || cfg.chans == '0 || cfg.chans > CH_RGBA)
            c_job_next.kind = KIND_WHITE;
        else if (last_byte >= MEM_LIMIT)
            c_job_next.kind = KIND_ERROR;
        else
            c_job_next.kind = KIND_READ;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready && req.command == CMD_SAMPLE)
                count_reg <= count_next;
            if (a_free)
                a_valid_reg <= req_valid;
            if (b_free)
                b_valid_reg <= a_valid_reg;
            if (c_free)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && req_valid)
        begin
            a_cmd_reg   <= req.command;
            a_waddr_reg <= req.write_address;
            a_wbyte_reg <= req.write_byte;
            a_count_reg <= count_next;
            a_px_reg    <= PROD_W'(req.coord_u[COORD_FRACTION_BITS-1:0]) * PROD_W'(w_eff);
            a_py_reg    <= PROD_W'(req.coord_v[COORD_FRACTION_BITS-1:0]) * PROD_W'(h_eff);
            a_w_reg     <= w_eff;
            a_h_reg     <= h_eff;
        end
        if (b_free && a_valid_reg)
        begin
            b_cmd_reg   <= a_cmd_reg;
            b_waddr_reg <= a_waddr_reg;
            b_wbyte_reg <= a_wbyte_reg;
            b_count_reg <= a_count_reg;
            b_lin_reg   <= lin_next;
        end
        if (c_free && b_valid_reg)
            c_job_reg <= c_job_next;
    end

    assign job_valid = c_valid_reg;
    assign job       = c_job_reg;

endmodule

// File: rtl/nts_queue.sv
// Short job queue between the front pipeline and the memory back end.
module nts_queue
    import nts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  nts_job_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output nts_job_t pop_data
);

    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   fill_reg;
    logic [QUEUE_AW:0]   fill_next;
    nts_job_t            entry_reg [QUEUE_DEPTH];
    logic                push;
    logic                pop;

    assign push_ready = fill_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + (QUEUE_AW + 1)'(1);
        else if (pop && !push)
            fill_next = fill_reg - (QUEUE_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/nts_back.sv
// Back end: four byte-interleaved texel banks, texel fetch, RGBA expansion, output register.
module nts_back
    import nts_pkg::*;
#(
    parameter int TEXEL_BYTES = 65536
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  nts_job_t job,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output nts_rsp_t rsp
);

    localparam int BANK_DEPTH = (TEXEL_BYTES + 3) / 4;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam logic [CMP_W-1:0] MEM_LIMIT = CMP_W'(TEXEL_BYTES);

    logic               pop;
    logic               rd_en;
    logic               write_ok;
    logic               r_free;
    logic               o_free;

    logic               r_valid_reg;
    logic [1:0]         r_kind_reg;
    logic [CHAN_W-1:0]  r_chans_reg;
    logic [1:0]         r_off_reg;
    logic [COUNT_W-1:0] r_count_reg;
    logic [7:0]         rd_data_reg [4];
    logic [7:0]         tex_byte [4];

    logic               rsp_valid_reg;
    nts_rsp_t           rsp_reg;
    nts_rsp_t           rsp_next;

    assign o_free    = !rsp_valid_reg || rsp_ready;
    assign r_free    = !r_valid_reg || o_free;
    assign job_ready = r_free;
    assign pop       = job_valid && r_free;
    assign rd_en     = pop && job.kind == KIND_READ;
    assign write_ok  = CMP_W'(job.waddr) < MEM_LIMIT;

    // bank b holds the bytes whose address is b modulo four
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [7:0]         mem [BANK_DEPTH];
        logic [1:0]         offset;
        logic [BASE_W-1:0]  byte_addr;
        logic [BANK_AW-1:0] rd_idx;
        logic [BANK_AW-1:0] wr_idx;
        logic               wr_en;

        assign offset    = 2'(b) - job.base[1:0];
        assign byte_addr = job.base + BASE_W'(offset);
        assign rd_idx    = BANK_AW'(byte_addr >> 2);
        assign wr_idx    = BANK_AW'(job.waddr >> 2);
        assign wr_en     = pop && job.kind == KIND_WRITE && write_ok
                           && job.waddr[1:0] == 2'(b);

        always_ff @(posedge clk)
        begin
            if (wr_en)
                mem[wr_idx] <= job.wbyte;
            if (rd_en)
                rd_data_reg[b] <= mem[rd_idx];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            tex_byte[k] = rd_data_reg[2'(r_off_reg + 2'(k))];
    end

    always_comb
    begin
        rsp_next.red           = FULL_BYTE;
        rsp_next.green         = FULL_BYTE;
        rsp_next.blue          = FULL_BYTE;
        rsp_next.alpha         = FULL_BYTE;
        rsp_next.samples_taken = r_count_reg;
        rsp_next.address_error = r_kind_reg == KIND_ERROR;
        if (r_kind_reg == KIND_READ)
        begin
            unique case (r_chans_reg)
                CH_GREY:
                begin
                    rsp_next.red   = tex_byte[0];
                    rsp_next.green = tex_byte[0];
                    rsp_next.blue  = tex_byte[0];
                end
                CH_GREY_ALPHA:
                begin
                    rsp_next.red   = tex_byte[0];
                    rsp_next.green = tex_byte[0];
                    rsp_next.blue  = tex_byte[0];
                    rsp_next.alpha = tex_byte[1];
                end
                CH_RGB:
                begin
                    rsp_next.red   = tex_byte[0];
                    rsp_next.green = tex_byte[1];
                    rsp_next.blue  = tex_byte[2];
                end
                CH_RGBA:
                begin
                    rsp_next.red   = tex_byte[0];
                    rsp_next.green = tex_byte[1];
                    rsp_next.blue  = tex_byte[2];
                    rsp_next.alpha = tex_byte[3];
                end
                default:
                begin
                    rsp_next.red = FULL_BYTE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // writes retire at the bank and never reach the output
            if (r_free)
                r_valid_reg <= pop && job.kind != KIND_WRITE;
            if (o_free)
                rsp_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            r_kind_reg  <= job.kind;
            r_chans_reg <= job.chans;
            r_off_reg   <= job.base[1:0];
            r_count_reg <= job.count;
        end
        if (o_free && r_valid_reg)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/nearest_texel_sampler_unit.sv
// Top level of the nearest texel sampler: configuration registers, front, queue, back.
//
//  channel   direction  handshake                     payload
//  req       in         req_valid / req_ready         nts_req_t (write or sample)
//  rsp       out        rsp_valid / rsp_ready         nts_rsp_t (one per sample)
//  cfg       in         cfg_write_en, no wait         cfg_index, cfg_data
//
// One transaction per cycle enters while the queue has room; the front multiplier
// pipeline and one access per texel bank keep that rate. A sample passes front stages
// a, b, c, the queue, read and output registers; a write lands in memory when popped.
// Reset clears the sample counter and loads width 1, height 1, four channels, no texture;
// texel memory has no reset and reads undefined until written.
// A stalled rsp holds its register; the four-entry queue absorbs back-end stalls.
module nearest_texel_sampler_unit
    import nts_pkg::*;
#(
    parameter int TEXEL_BYTES         = 65536,
    parameter int MAX_DIMENSION       = 256,
    parameter int COORD_FRACTION_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  nts_req_t               req,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output nts_rsp_t               rsp,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    nts_cfg_t cfg_reg;
    logic     job_valid;
    logic     job_ready;
    nts_job_t job;
    logic     q_valid;
    logic     q_ready;
    nts_job_t q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width   <= DIM_W'(1);
            cfg_reg.height  <= DIM_W'(1);
            cfg_reg.chans   <= CH_RGBA;
            cfg_reg.present <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_WIDTH:    cfg_reg.width   <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:   cfg_reg.height  <= cfg_data[DIM_W-1:0];
                REG_CHANNELS: cfg_reg.chans   <= cfg_data[CHAN_W-1:0];
                REG_PRESENT:  cfg_reg.present <= cfg_data[0];
                default:      cfg_reg.present <= cfg_reg.present;
            endcase
        end
    end

    nts_front #(
        .MAX_DIMENSION       (MAX_DIMENSION),
        .COORD_FRACTION_BITS (COORD_FRACTION_BITS),
        .TEXEL_BYTES         (TEXEL_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    nts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_valid),
        .push_ready (job_ready),
        .push_data  (job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_job)
    );

    nts_back #(
        .TEXEL_BYTES (TEXEL_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// File: rtl/nts_checker.sv
// Port-level checks for the nearest texel sampler, bound to the top level.
module nts_checker
    import nts_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input nts_req_t               req,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input nts_rsp_t               rsp,
    input logic                   cfg_write_en
);

    logic [3:0]         pending_reg;
    logic [COUNT_W-1:0] last_count_reg;
    logic               sample_in;
    logic               rsp_out;

    assign sample_in = req_valid && req_ready && req.command == CMD_SAMPLE;
    assign rsp_out   = rsp_valid && rsp_ready;

    // samples accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_count_reg <= '0;
        end
        else
        begin
            if (sample_in && !rsp_out)
                pending_reg <= pending_reg + 4'd1;
            else if (rsp_out && !sample_in)
                pending_reg <= pending_reg - 4'd1;
            if (rsp_out)
                last_count_reg <= rsp.samples_taken;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 4'd0)
        else $error("rsp without an outstanding sample");

    a_error_white: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.address_error |->
            rsp.red == FULL_BYTE && rsp.green == FULL_BYTE
            && rsp.blue == FULL_BYTE && rsp.alpha == FULL_BYTE)
        else $error("address error without white color");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_out |-> rsp.samples_taken == last_count_reg + COUNT_W'(1))
        else $error("sample count skipped or repeated");

    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |-> pending_reg == 4'd0)
        else $error("configuration written with samples in flight");

endmodule

bind nearest_texel_sampler_unit nts_checker u_nts_checker (.*);

// File: sim/tb_nearest_texel_sampler_unit.sv
// Self-checking testbench for the nearest texel sampler: directed table, then random phases.
`timescale 1ns / 100ps

module tb_nearest_texel_sampler_unit;
    import nts_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int TEXEL_BYTES   = 65536;
    localparam int MAX_DIMENSION = 256;
    localparam int FRACTION_BITS = 16;
    localparam int ITEM_TARGET   = 1500;
    localparam int PHASE_ITEMS   = 125;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PERCENT  = 34;
    localparam int TIMEOUT_NS    = 2_000_000;

    // channel counts the block must treat as no format
    localparam logic [CHAN_W-1:0] CHANS_ZERO = 3'd0;
    localparam logic [CHAN_W-1:0] CHANS_FIVE = 3'd5;
    localparam logic [CHAN_W-1:0] CHANS_TOP  = 3'd7;

    typedef enum logic {ROW_SETUP, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [CHAN_W-1:0] chans;
        logic              present;
        nts_req_t          item;
        bit                typed;
        nts_rsp_t          want;
    } plan_row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   req_valid    = 1'b0;
    logic                   req_ready;
    nts_req_t               req          = '0;
    logic                   rsp_valid;
    logic                   rsp_ready    = 1'b0;
    nts_rsp_t               rsp;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // predictor state
    logic [7:0]        texel_copy [TEXEL_BYTES];
    bit                byte_known [TEXEL_BYTES];
    logic [31:0]       samples_seen = '0;
    logic [DIM_W-1:0]  cur_width    = 9'd1;
    logic [DIM_W-1:0]  cur_height   = 9'd1;
    logic [CHAN_W-1:0] cur_chans    = CH_RGBA;
    logic              cur_present  = 1'b0;

    nts_rsp_t  expected_texels [$];
    plan_row_t directed_plan [$];
    int        mismatch_count        = 0;
    int        transactions_accepted = 0;
    bit        steady_run            = 1'b0;

    nearest_texel_sampler_unit #(
        .TEXEL_BYTES         (TEXEL_BYTES),
        .MAX_DIMENSION       (MAX_DIMENSION),
        .COORD_FRACTION_BITS (FRACTION_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int eff_dim(logic [DIM_W-1:0] d);
        if (d == 0)
        begin
            return 1;
        end
        if (d > MAX_DIMENSION)
        begin
            return MAX_DIMENSION;
        end
        return int'(d);
    endfunction

    // byte address of the texel hit by u, v under the current setting
    function automatic int texel_addr(logic [31:0] u, logic [31:0] v);
        int w;
        int h;
        int x;
        int y;
        w = eff_dim(cur_width);
        h = eff_dim(cur_height);
        x = (int'(u[FRACTION_BITS-1:0]) * w) >> FRACTION_BITS;
        y = (int'(v[FRACTION_BITS-1:0]) * h) >> FRACTION_BITS;
        if (x >= w)
        begin
            x = w - 1;
        end
        if (y >= h)
        begin
            y = h - 1;
        end
        y = h - 1 - y;
        return (y * w + x) * int'(cur_chans);
    endfunction

    function automatic nts_rsp_t predict_texel(nts_req_t item);
        nts_rsp_t res;
        int       base;
        samples_seen++;
        res.red           = FULL_BYTE;
        res.green         = FULL_BYTE;
        res.blue          = FULL_BYTE;
        res.alpha         = FULL_BYTE;
        res.samples_taken = samples_seen;
        res.address_error = 1'b0;
        if (cur_present && cur_chans >= CH_GREY && cur_chans <= CH_RGBA)
        begin
            base = texel_addr(item.coord_u, item.coord_v);
            if (base + int'(cur_chans) > TEXEL_BYTES)
            begin
                res.address_error = 1'b1;
            end
            else
            begin
                res.red = texel_copy[base];
                case (cur_chans)
                    CH_GREY:
                    begin
                        res.green = res.red;
                        res.blue  = res.red;
                    end
                    CH_GREY_ALPHA:
                    begin
                        res.green = res.red;
                        res.blue  = res.red;
                        res.alpha = texel_copy[base + 1];
                    end
                    CH_RGB:
                    begin
                        res.green = texel_copy[base + 1];
                        res.blue  = texel_copy[base + 2];
                    end
                    default:
                    begin
                        res.green = texel_copy[base + 1];
                        res.blue  = texel_copy[base + 2];
                        res.alpha = texel_copy[base + 3];
                    end
                endcase
            end
        end
        return res;
    endfunction

    function automatic nts_req_t make_write(logic [15:0] addr, logic [7:0] data);
        nts_req_t item;
        item.command       = CMD_WRITE;
        item.coord_u       = $urandom;
        item.coord_v       = $urandom;
        item.write_address = addr;
        item.write_byte    = data;
        return item;
    endfunction

    function automatic nts_req_t make_sample(logic [31:0] u, logic [31:0] v);
        nts_req_t item;
        item.command       = CMD_SAMPLE;
        item.coord_u       = u;
        item.coord_v       = v;
        item.write_address = 16'($urandom);
        item.write_byte    = 8'($urandom);
        return item;
    endfunction

    function automatic void plan_setup(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                       logic [CHAN_W-1:0] c, logic p);
        plan_row_t row;
        row         = '{kind: ROW_SETUP, default: '0};
        row.width   = w;
        row.height  = h;
        row.chans   = c;
        row.present = p;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_item(nts_req_t item);
        plan_row_t row;
        row      = '{kind: ROW_ITEM, default: '0};
        row.item = item;
        directed_plan.push_back(row);
    endfunction

    // sample whose outcome is plain white, with a known count
    function automatic void plan_white(logic [31:0] u, logic [31:0] v, logic err,
                                       logic [31:0] count);
        plan_row_t row;
        row                    = '{kind: ROW_ITEM, default: '0};
        row.item               = make_sample(u, v);
        row.typed              = 1'b1;
        row.want.red           = FULL_BYTE;
        row.want.green         = FULL_BYTE;
        row.want.blue          = FULL_BYTE;
        row.want.alpha         = FULL_BYTE;
        row.want.samples_taken = count;
        row.want.address_error = err;
        directed_plan.push_back(row);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'($urandom_range(257, 511));
            3:       return 9'd1;
            default: return 9'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chans();
        if ($urandom_range(9) < 8)
        begin
            return 3'($urandom_range(CH_GREY, CH_RGBA));
        end
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return {16'($urandom), 16'hFFFF};
            3:       return {16'($urandom), 16'h0000};
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_texel(input nts_rsp_t got);
        nts_rsp_t want;
        if (expected_texels.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending, samples_taken %0d",
                                      got.samples_taken));
            return;
        end
        want = expected_texels.pop_front();
        if (got.red !== want.red)
            report_mismatch($sformatf("sample %0d red %0h want %0h",
                                      want.samples_taken, got.red, want.red));
        if (got.green !== want.green)
            report_mismatch($sformatf("sample %0d green %0h want %0h",
                                      want.samples_taken, got.green, want.green));
        if (got.blue !== want.blue)
            report_mismatch($sformatf("sample %0d blue %0h want %0h",
                                      want.samples_taken, got.blue, want.blue));
        if (got.alpha !== want.alpha)
            report_mismatch($sformatf("sample %0d alpha %0h want %0h",
                                      want.samples_taken, got.alpha, want.alpha));
        if (got.samples_taken !== want.samples_taken)
            report_mismatch($sformatf("samples_taken %0d want %0d",
                                      got.samples_taken, want.samples_taken));
        if (got.address_error !== want.address_error)
            report_mismatch($sformatf("sample %0d address_error %0b want %0b",
                                      want.samples_taken, got.address_error,
                                      want.address_error));
    endtask

    // called at a rising edge; returns at the edge where the transaction is accepted
    task automatic push_request(input nts_req_t item, input bit typed, input nts_rsp_t want);
        nts_rsp_t guess;
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        transactions_accepted++;
        if (item.command == CMD_WRITE)
        begin
            texel_copy[item.write_address] = item.write_byte;
            byte_known[item.write_address] = 1'b1;
        end
        else
        begin
            guess = predict_texel(item);
            expected_texels.push_back(typed ? want : guess);
        end
    endtask

    // any byte the sample would read and that was never written is written first
    task automatic send_sample(input logic [31:0] u, input logic [31:0] v,
                               input bit typed, input nts_rsp_t want);
        int base;
        if (cur_present && cur_chans >= CH_GREY && cur_chans <= CH_RGBA)
        begin
            base = texel_addr(u, v);
            if (base + int'(cur_chans) <= TEXEL_BYTES)
            begin
                for (int k = 0; k < int'(cur_chans); k++)
                begin
                    if (!byte_known[base + k])
                        push_request(make_write(16'(base + k), 8'($urandom)), 1'b0, '0);
                end
            end
        end
        push_request(make_sample(u, v), typed, want);
    endtask

    // also gives the write pipeline time to land before a register changes
    task automatic drain_block();
        req_valid <= 1'b0;
        while (expected_texels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        case (idx)
            REG_WIDTH:    cur_width   = data[DIM_W-1:0];
            REG_HEIGHT:   cur_height  = data[DIM_W-1:0];
            REG_CHANNELS: cur_chans   = data[CHAN_W-1:0];
            REG_PRESENT:  cur_present = data[0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_texture(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [CHAN_W-1:0] c, input logic p);
        drain_block();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_CHANNELS, CFG_DATA_W'(c));
        write_reg(REG_PRESENT, CFG_DATA_W'(p));
        cfg_write_en <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            check_texel(rsp);
        rsp_ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int phase_end;

        // reset setting: no texture, so samples are white
        plan_white(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'd1);
        plan_white(32'h0000_0000, 32'h0000_0000, 1'b0, 32'd2);
        plan_item(make_write(16'hFFFF, 8'hFF));
        plan_item(make_write(16'h0000, 8'h00));
        plan_setup(9'd1, 9'd1, CH_GREY, 1'b1);
        plan_item(make_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // full size RGBA runs past the end of memory in the upper rows
        plan_setup(9'd256, 9'd256, CH_RGBA, 1'b1);
        plan_white(32'h0000_FFFF, 32'h0000_0000, 1'b1, 32'd4);
        plan_item(make_sample(32'h0000_0000, 32'h0000_FFFF));
        plan_white(32'h8000_0000, 32'h0000_8000, 1'b1, 32'd6);
        // zero width and oversize height
        plan_setup(9'd0, 9'd511, CH_GREY_ALPHA, 1'b1);
        plan_item(make_sample(32'h1234_5678, 32'h0001_0000));
        plan_item(make_sample(32'hFFFF_0000, 32'hFFFF_FFFF));
        plan_setup(9'd256, 9'd1, CH_RGB, 1'b1);
        plan_item(make_sample(32'hFFFF_FFFF, 32'h0000_0000));
        plan_item(make_sample(32'h0000_0001, 32'h7FFF_0000));
        // last texel ends exactly on the last byte
        plan_setup(9'd256, 9'd128, CH_GREY_ALPHA, 1'b1);
        plan_item(make_sample(32'h0000_FFFF, 32'h0000_0000));
        plan_setup(9'd256, 9'd256, CHANS_ZERO, 1'b1);
        plan_white(32'h0000_0000, 32'h0000_0000, 1'b0, 32'd12);
        plan_setup(9'd256, 9'd256, CHANS_TOP, 1'b1);
        plan_white(32'h0000_FFFF, 32'h0000_0000, 1'b0, 32'd13);
        plan_setup(9'd256, 9'd256, CHANS_FIVE, 1'b1);
        plan_white(32'h0000_8000, 32'h0000_8000, 1'b0, 32'd14);
        plan_setup(9'd256, 9'd256, CH_GREY, 1'b1);
        plan_item(make_sample(32'h0000_FFFF, 32'h0000_0000));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_SETUP)
                set_texture(directed_plan[i].width, directed_plan[i].height,
                            directed_plan[i].chans, directed_plan[i].present);
            else if (directed_plan[i].item.command == CMD_WRITE)
                push_request(directed_plan[i].item, 1'b0, '0);
            else
                send_sample(directed_plan[i].item.coord_u, directed_plan[i].item.coord_v,
                            directed_plan[i].typed, directed_plan[i].want);
        end

        for (int phase = 0; transactions_accepted < ITEM_TARGET; phase++)
        begin
            case (phase)
                0:       set_texture(9'd256, 9'd256, CH_RGBA, 1'b1);
                1:       set_texture(9'd1, 9'd1, CH_GREY, 1'b1);
                2:       set_texture(9'd511, 9'd0, CH_GREY_ALPHA, 1'b1);
                default: set_texture(pick_dim(), pick_dim(), pick_chans(),
                                     1'($urandom_range(9) != 0));
            endcase
            steady_run = (phase == 4);
            phase_end  = transactions_accepted + PHASE_ITEMS;
            while (transactions_accepted < phase_end)
            begin
                if ($urandom_range(99) < 20)
                    push_request(make_write(16'($urandom), 8'($urandom)), 1'b0, '0);
                else
                    send_sample(pick_coord(), pick_coord(), 1'b0, '0);
            end
        end

        steady_run = 1'b0;
        drain_block();
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: nearest_texel_sampler_unit.f
rtl/nts_pkg.sv
rtl/nts_front.sv
rtl/nts_queue.sv
rtl/nts_back.sv
rtl/nearest_texel_sampler_unit.sv
rtl/nts_checker.sv
sim/tb_nearest_texel_sampler_unit.sv
